### sv/ttg_pkg.sv
package ttg_pkg;

   // Finger slots carried by one report
   localparam int TIP_W = 5;

   typedef struct packed {
      logic [TIP_W-1:0] tip_mask;
      logic [31:0]      now_ms;
   } req_type;

   typedef struct packed {
      logic       button_down;
      logic       hold_active;
      logic [2:0] gesture_state;
   } rsp_type;

   typedef logic [2:0] phase_type;

   localparam phase_type PH_IDLE  = 3'd0;
   localparam phase_type PH_PMOVE = 3'd1;
   localparam phase_type PH_MOVE  = 3'd2;
   localparam phase_type PH_PHOLD = 3'd3;
   localparam phase_type PH_HOLD  = 3'd4;
   localparam phase_type PH_ABORT = 3'd5;

   localparam logic [3:0] FINGER_NONE = 4'hF;

   // Register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_MOVE_DELAY = 2'd0;
   localparam logic [1:0] REG_TAP_WINDOW = 2'd1;
   localparam logic [1:0] REG_KEEP_HOLD  = 2'd2;

   localparam logic [15:0] MOVE_DELAY_RST = 16'd100;
   localparam logic [15:0] TAP_WINDOW_RST = 16'd250;
   localparam logic        KEEP_HOLD_RST  = 1'b1;

   typedef struct packed {
      logic [15:0] move_delay_ms;
      logic [15:0] tap_window_ms;
      logic        keep_hold;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  first_finger;
      logic [31:0] phase_start_ms;
      logic [2:0]  prev_count;
   } gst_type;

endpackage

### sv/ttg_step.sv
module ttg_step #(
   parameter int ScanSlots = 5
) (
   input  ttg_pkg::cfg_type cfg,
   input  ttg_pkg::gst_type gst_cur,
   input  ttg_pkg::req_type req,
   output ttg_pkg::gst_type gst_nxt,
   output ttg_pkg::rsp_type rsp
);

   ttg_pkg::phase_type ph;
   logic [3:0]  ff;
   logic        restart;
   logic [2:0]  cnt;
   logic        button;
   logic [31:0] start_scan;
   logic [31:0] start_nxt;
   logic [31:0] elapsed;

   always_comb begin
      ph      = gst_cur.phase;
      ff      = gst_cur.first_finger;
      restart = 1'b0;
      cnt     = '0;
      button  = 1'b0;

      // Scan the slots in index order
      for (int i = 0; i < ScanSlots; i++) begin
         if (req.tip_mask[i]) begin
            cnt = cnt + 3'd1;
            if (ff == ttg_pkg::FINGER_NONE) begin
               ff      = 4'(i);
               ph      = ttg_pkg::PH_PMOVE;
               restart = 1'b1;
            end
         end else if (!(cfg.keep_hold && ph == ttg_pkg::PH_HOLD) && ff == 4'(i)) begin
            ff = ttg_pkg::FINGER_NONE;
            ph = ttg_pkg::PH_ABORT;
         end
      end

      start_scan = restart ? req.now_ms : gst_cur.phase_start_ms;
      start_nxt  = start_scan;
      elapsed    = req.now_ms - start_scan;

      if (!(cfg.keep_hold && ph == ttg_pkg::PH_HOLD) && cnt == 3'd0) begin
         ph = ttg_pkg::PH_IDLE;
         ff = ttg_pkg::FINGER_NONE;
      end

      unique case (ph)
         ttg_pkg::PH_PMOVE: begin
            if (cnt != 3'd1) begin
               ph = ttg_pkg::PH_ABORT;
            end else if (elapsed > {16'd0, cfg.move_delay_ms}) begin
               ph = ttg_pkg::PH_MOVE;
            end
         end
         ttg_pkg::PH_MOVE: begin
            if (cnt == 3'd2) begin
               ph        = ttg_pkg::PH_PHOLD;
               start_nxt = req.now_ms;
            end
         end
         ttg_pkg::PH_PHOLD: begin
            if (cnt == 3'd1) begin
               ph     = ttg_pkg::PH_HOLD;
               button = 1'b1;
            end else if (elapsed > {16'd0, cfg.tap_window_ms}) begin
               ph = ttg_pkg::PH_ABORT;
            end
         end
         ttg_pkg::PH_HOLD: begin
            if (cnt == 3'd1 && gst_cur.prev_count > 3'd1) begin
               ph = ttg_pkg::PH_MOVE;
            end
            button = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign gst_nxt.phase          = ph;
   assign gst_nxt.first_finger   = ff;
   assign gst_nxt.phase_start_ms = start_nxt;
   assign gst_nxt.prev_count     = cnt;

   assign rsp.button_down   = button;
   assign rsp.hold_active   = (ph == ttg_pkg::PH_HOLD);
   assign rsp.gesture_state = ph;

endmodule

### sv/touchpad_tap_hold_gesture_unit.sv
// A report beat passes the input register, then the result register (two registers).
// Throughput: one report per cycle while the result side takes beats; the gesture update is one
// combinational pass between the input register and the result register, with the gesture state
// written as the beat moves. Stalls on the result side hold the result register; the input register
// keeps taking a beat whenever its content moves on in the same cycle.
// Reset (synchronous, active high): clears both valids, returns the gesture to idle with no
// first finger, and loads the registers with 100 ms, 250 ms and hold lock on.
module touchpad_tap_hold_gesture_unit #(
   parameter int FINGER_SLOTS = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ttg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ttg_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   // Slots beyond the report's mask width never touch, so scan at most that many
   localparam int ScanSlots = (FINGER_SLOTS < ttg_pkg::TIP_W) ? FINGER_SLOTS : ttg_pkg::TIP_W;

   ttg_pkg::cfg_type cfg_ff;
   ttg_pkg::gst_type gst_ff;
   ttg_pkg::gst_type gst_in;
   ttg_pkg::req_type req_data_ff;
   ttg_pkg::rsp_type rsp_data_ff;
   ttg_pkg::rsp_type rsp_in;
   logic             req_valid_ff;
   logic             rsp_valid_ff;
   logic             advance;
   logic             csr_write;
   logic [1:0]       csr_index;

   // ---------------------------------------------------------------
   // Configuration port: write on the access phase, read is combinational
   // ---------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_delay_ms <= ttg_pkg::MOVE_DELAY_RST;
         cfg_ff.tap_window_ms <= ttg_pkg::TAP_WINDOW_RST;
         cfg_ff.keep_hold     <= ttg_pkg::KEEP_HOLD_RST;
      end else if (csr_write) begin
         if (csr_index == ttg_pkg::REG_MOVE_DELAY) begin
            cfg_ff.move_delay_ms <= pwdata[15:0];
         end
         if (csr_index == ttg_pkg::REG_TAP_WINDOW) begin
            cfg_ff.tap_window_ms <= pwdata[15:0];
         end
         if (csr_index == ttg_pkg::REG_KEEP_HOLD) begin
            cfg_ff.keep_hold <= pwdata[0];
         end
      end
   end

   always_comb begin
      unique case (csr_index)
         ttg_pkg::REG_MOVE_DELAY: prdata = {16'd0, cfg_ff.move_delay_ms};
         ttg_pkg::REG_TAP_WINDOW: prdata = {16'd0, cfg_ff.tap_window_ms};
         ttg_pkg::REG_KEEP_HOLD:  prdata = {31'd0, cfg_ff.keep_hold};
         default:                 prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Beat flow: advance moves the input register into the result register
   // and commits the gesture state in the same edge.
   // ---------------------------------------------------------------
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   // Payload only: no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff <= req_data;
      end
   end

   ttg_step #(
      .ScanSlots (ScanSlots)
   ) u_step (
      .cfg     (cfg_ff),
      .gst_cur (gst_ff),
      .req     (req_data_ff),
      .gst_nxt (gst_in),
      .rsp     (rsp_in)
   );

   // Gesture state: idle, no first finger, zero timestamp and count after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         gst_ff.phase          <= ttg_pkg::PH_IDLE;
         gst_ff.first_finger   <= ttg_pkg::FINGER_NONE;
         gst_ff.phase_start_ms <= '0;
         gst_ff.prev_count     <= '0;
      end else if (advance) begin
         gst_ff <= gst_in;
      end
   end

   // Result register: load on advance, drop valid once the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/ttg_checker.sv
module ttg_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ttg_pkg::rsp_type rsp_data
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // No result beat right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Hold flag agrees with the reported state, and a hold always presses the button
   a_hold_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hold_active == (rsp_data.gesture_state == ttg_pkg::PH_HOLD))
                    && (!rsp_data.hold_active || rsp_data.button_down))
      else $error("hold flag inconsistent with state or button");

   // Button only pressed in hold, or on the tap that drops a hold back to move
   a_button_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.button_down |->
         (rsp_data.gesture_state == ttg_pkg::PH_HOLD)
         || (rsp_data.gesture_state == ttg_pkg::PH_MOVE))
      else $error("button pressed outside hold");

endmodule

bind touchpad_tap_hold_gesture_unit ttg_checker u_ttg_checker (.*);
